>>> rtl/core/branch_condition_unit_core_defines.svh
// Assertion macros for the branch and condition-register unit checker.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef BRANCH_CONDITION_UNIT_CORE_DEFINES_SVH
`define BRANCH_CONDITION_UNIT_CORE_DEFINES_SVH

// Clocked check, switched off while reset is asserted.
`define BCU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BCU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bcu_pkg.sv
// Shared types and constants for the branch and condition-register unit.
// No dependencies.
package bcu_pkg;

    typedef enum logic [2:0] {
        REQ_BRANCH   = 3'd0,
        REQ_CMP_S    = 3'd1,
        REQ_CMP_U    = 3'd2,
        REQ_CMP_F    = 3'd3,
        REQ_REC_CR0  = 3'd4,
        REQ_LOAD_CTR = 3'd5
    } req_type_e;

    // CR field nibble codes
    localparam logic [3:0] CMP_LT = 4'h8;
    localparam logic [3:0] CMP_GT = 4'h4;
    localparam logic [3:0] CMP_EQ = 4'h2;
    localparam logic [3:0] CMP_UN = 4'h1;

    localparam logic [31:0] SIGN32 = 32'h8000_0000;
    localparam logic [31:0] PC_STEP = 32'd4;

    // BO bit positions (bit 4 is BO0)
    localparam int unsigned BO0 = 4;
    localparam int unsigned BO1 = 3;
    localparam int unsigned BO2 = 2;
    localparam int unsigned BO3 = 1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  branch_options;
        logic [4:0]  cond_bit;
        logic [31:0] target;
        logic        absolute;
        logic        link;
        logic [31:0] current_pc;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
        logic [2:0]  cr_field;
        logic        summary_overflow;
    } req_t;

    typedef struct packed {
        logic        taken;
        logic [31:0] next_pc;
        logic [31:0] ctr;
    } br_res_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        taken;
        logic [31:0] cr_value;
        logic [31:0] ctr_value;
        logic [31:0] lr_value;
    } result_t;

endpackage

>>> rtl/core/bcu_cmp.sv
// Compare unit: integer (signed/unsigned), record-CR0 and IEEE double
// compares, giving one CR field nibble. Depends on bcu_pkg.
module bcu_cmp
    import bcu_pkg::*;
(
    input  req_type_e   op,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic        summary_overflow,
    output logic [3:0]  nibble
);

    logic        int_signed;
    logic [31:0] int_x;
    logic [31:0] int_y;
    logic [3:0]  int_nibble;
    logic        nan_a;
    logic        nan_b;
    logic        both_zero;
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [3:0]  flt_nibble;

    // Signed compare becomes unsigned once the sign bits are flipped
    assign int_signed = (op == REQ_CMP_S) || (op == REQ_REC_CR0);
    assign int_x = operand_a[31:0] ^ (int_signed ? SIGN32 : 32'd0);
    assign int_y = ((op == REQ_REC_CR0) ? 32'd0 : operand_b[31:0])
                   ^ (int_signed ? SIGN32 : 32'd0);

    always_comb
    begin
        if (int_x < int_y)
            int_nibble = CMP_LT | {3'b000, summary_overflow};
        else if (int_x > int_y)
            int_nibble = CMP_GT | {3'b000, summary_overflow};
        else
            int_nibble = CMP_EQ | {3'b000, summary_overflow};
    end

    assign nan_a = (&operand_a[62:52]) && (|operand_a[51:0]);
    assign nan_b = (&operand_b[62:52]) && (|operand_b[51:0]);
    assign both_zero = ~|{operand_a[62:0], operand_b[62:0]};
    // Monotonic keys: negative values inverted, positive get the top bit set
    assign key_a = operand_a[63] ? ~operand_a : (operand_a | {1'b1, 63'd0});
    assign key_b = operand_b[63] ? ~operand_b : (operand_b | {1'b1, 63'd0});

    always_comb
    begin
        priority if (nan_a || nan_b)
            flt_nibble = CMP_UN;
        else if (both_zero)
            flt_nibble = CMP_EQ;
        else if (key_a < key_b)
            flt_nibble = CMP_LT;
        else if (key_a > key_b)
            flt_nibble = CMP_GT;
        else
            flt_nibble = CMP_EQ;
    end

    assign nibble = (op == REQ_CMP_F) ? flt_nibble : int_nibble;

endmodule

>>> rtl/core/bcu_branch.sv
// Conditional branch evaluation: BO decode, CTR decrement and test,
// CR bit test and target select. Depends on bcu_pkg.
module bcu_branch
    import bcu_pkg::*;
(
    input  logic [4:0]  branch_options,
    input  logic [4:0]  cond_bit,
    input  logic [31:0] target,
    input  logic        absolute,
    input  logic [31:0] current_pc,
    input  logic [31:0] cr,
    input  logic [31:0] ctr,
    output br_res_t     res
);

    logic [31:0] ctr_new;
    logic        ctr_ok;
    logic        cond_ok;
    logic        cr_bit;

    assign ctr_new = branch_options[BO2] ? ctr : (ctr - 32'd1);
    assign ctr_ok  = branch_options[BO2] || ((ctr_new != 32'd0) ^ branch_options[BO3]);
    // CR bit 0 is the MSB, so bit n sits at vector index 31 - n
    assign cr_bit  = cr[~cond_bit];
    assign cond_ok = branch_options[BO0] || (cr_bit == branch_options[BO1]);

    always_comb
    begin
        res.ctr   = ctr_new;
        res.taken = ctr_ok && cond_ok;
        if (res.taken)
            res.next_pc = absolute ? target : (target + current_pc);
        else
            res.next_pc = current_pc + PC_STEP;
    end

endmodule

>>> rtl/core/branch_condition_unit_core.sv
// Top level of the branch and condition-register unit.
// Depends on bcu_pkg, bcu_cmp and bcu_branch.
//
// PowerPC-style branch and condition-register unit holding CR, CTR and LR
// (all zero after reset). It takes one item per clock while the output is
// not stalled and returns exactly one result item per input item, in order.
// An accepted item waits in the input register, where the compare unit and
// the branch unit evaluate it against the current CR/CTR/LR; the CR, CTR
// and LR registers and the result register are written together when
// the item advances, so the following item already sees the updated state.
// Throughput is one item per cycle while out_ready stays high, set by that
// single evaluate stage; a stalled output holds the result register and
// the input register takes one more item before in_ready drops.
// Request codes 6 and 7 change no state and return current_pc + 4.
module branch_condition_unit_core
    import bcu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [4:0]  branch_options,
    input  logic [4:0]  cond_bit,
    input  logic [31:0] target,
    input  logic        absolute,
    input  logic        link,
    input  logic [31:0] current_pc,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic [2:0]  cr_field,
    input  logic        summary_overflow,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] next_pc,
    output logic        taken,
    output logic [31:0] cr_value,
    output logic [31:0] ctr_value,
    output logic [31:0] lr_value
);

    // Input register (stage 1)
    req_t        req_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    // Result register (stage 2)
    result_t     res_reg;
    result_t     res_next;
    logic        s2_valid_reg;
    logic        s2_valid_next;
    // Architectural state
    logic [31:0] cr_reg;
    logic [31:0] cr_next;
    logic [31:0] ctr_reg;
    logic [31:0] ctr_next;
    logic [31:0] lr_reg;
    logic [31:0] lr_next;

    logic        in_fire;
    logic        s1_advance;
    req_type_e   op;
    logic [3:0]  cmp_nibble;
    logic [2:0]  dest_field;
    br_res_t     br_res;

    // Handshake: stage 1 moves on whenever stage 2 is empty or being drained
    assign s1_advance = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_advance);
    assign s2_valid_next = s1_advance || (s2_valid_reg && !out_ready);

    assign op = req_type_e'(req_reg.req_type);

    bcu_cmp u_cmp (
        .op               (op),
        .operand_a        (req_reg.operand_a),
        .operand_b        (req_reg.operand_b),
        .summary_overflow (req_reg.summary_overflow),
        .nibble           (cmp_nibble)
    );

    bcu_branch u_branch (
        .branch_options (req_reg.branch_options),
        .cond_bit       (req_reg.cond_bit),
        .target         (req_reg.target),
        .absolute       (req_reg.absolute),
        .current_pc     (req_reg.current_pc),
        .cr             (cr_reg),
        .ctr            (ctr_reg),
        .res            (br_res)
    );

    // Record CR0 always targets field 0
    assign dest_field = (op == REQ_REC_CR0) ? 3'd0 : req_reg.cr_field;

    // State update for the item in stage 1
    always_comb
    begin
        cr_next  = cr_reg;
        ctr_next = ctr_reg;
        lr_next  = lr_reg;
        res_next.next_pc = req_reg.current_pc + PC_STEP;
        res_next.taken   = 1'b0;
        unique case (op)
            REQ_BRANCH:
            begin
                ctr_next         = br_res.ctr;
                res_next.next_pc = br_res.next_pc;
                res_next.taken   = br_res.taken;
                if (req_reg.link)
                    lr_next = req_reg.current_pc + PC_STEP;
            end
            REQ_CMP_S, REQ_CMP_U, REQ_CMP_F, REQ_REC_CR0:
            begin
                // Field 0 is the most significant nibble
                for (int i = 0; i < 8; i++)
                begin
                    if (dest_field == 3'(i))
                        cr_next[31 - 4*i -: 4] = cmp_nibble;
                end
            end
            REQ_LOAD_CTR:
                ctr_next = req_reg.operand_a[31:0];
            default:
                ;
        endcase
        res_next.cr_value  = cr_next;
        res_next.ctr_value = ctr_next;
        res_next.lr_value  = lr_next;
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            cr_reg       <= 32'd0;
            ctr_reg      <= 32'd0;
            lr_reg       <= 32'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (s1_advance)
            begin
                cr_reg  <= cr_next;
                ctr_reg <= ctr_next;
                lr_reg  <= lr_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg.req_type         <= req_type;
            req_reg.branch_options   <= branch_options;
            req_reg.cond_bit         <= cond_bit;
            req_reg.target           <= target;
            req_reg.absolute         <= absolute;
            req_reg.link             <= link;
            req_reg.current_pc       <= current_pc;
            req_reg.operand_a        <= operand_a;
            req_reg.operand_b        <= operand_b;
            req_reg.cr_field         <= cr_field;
            req_reg.summary_overflow <= summary_overflow;
        end
        if (s1_advance)
            res_reg <= res_next;
    end

    assign out_valid = s2_valid_reg;
    assign next_pc   = res_reg.next_pc;
    assign taken     = res_reg.taken;
    assign cr_value  = res_reg.cr_value;
    assign ctr_value = res_reg.ctr_value;
    assign lr_value  = res_reg.lr_value;

endmodule

>>> rtl/core/bcu_checker.sv
// Port-level checker for branch_condition_unit_core, bound to the top level.
// Depends on branch_condition_unit_core_defines.svh.
`include "branch_condition_unit_core_defines.svh"

module bcu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] next_pc,
    input logic        taken,
    input logic [31:0] cr_value,
    input logic [31:0] ctr_value,
    input logic [31:0] lr_value
);

    logic         out_stall;
    logic [128:0] out_item;

    assign out_stall = out_valid && !out_ready;
    assign out_item  = {next_pc, taken, cr_value, ctr_value, lr_value};

    // A stalled result stays offered and unchanged
    `BCU_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_item), "stalled result changed")

    // Input only backs up when the output is full and stalled
    `BCU_ASSERT(a_ready_only_on_stall, !in_ready |-> out_stall, "in_ready low without output stall")

    // An accept is followed by out_valid once the item has passed the input and result registers
    `BCU_ASSERT(a_latency, in_valid && in_ready |-> ##2 out_valid, "result missing after accept")

    // No result while in reset
    `BCU_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind branch_condition_unit_core bcu_checker u_bcu_checker (.*);

>>> tb/bcu_tb_pkg.sv
// Scoreboard for the branch and condition-register unit testbench: a CR/CTR/LR
// predictor plus an in-order queue of the result items it expects.
// Depends on bcu_pkg for the request and result types and the CR nibble codes.
package bcu_tb_pkg;
    import bcu_pkg::*;

    // request codes the block leaves unused
    localparam logic [2:0] REQ_RESERVED_6 = 3'd6;
    localparam logic [2:0] REQ_RESERVED_7 = 3'd7;

    localparam logic [63:0] DBL_MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

    class bcu_state_tracker;
        logic [31:0] cr;
        logic [31:0] ctr;
        logic [31:0] lr;
        result_t     pending_results[$];
        int          errors;

        function new();
            cr = '0;
            ctr = '0;
            lr = '0;
            errors = 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void put_cr_field(logic [2:0] fld, logic [3:0] nib);
            cr[28 - 4 * int'(fld) +: 4] = nib;
        endfunction

        function logic [3:0] int_order(logic [31:0] a, logic [31:0] b, bit signed_cmp,
                                       logic so);
            logic lt;
            logic gt;
            lt = signed_cmp ? ($signed(a) < $signed(b)) : (a < b);
            gt = signed_cmp ? ($signed(a) > $signed(b)) : (a > b);
            if (lt)
                return CMP_LT | {3'b000, so};
            if (gt)
                return CMP_GT | {3'b000, so};
            return CMP_EQ | {3'b000, so};
        endfunction

        function bit dbl_is_nan(logic [63:0] v);
            return (v[62:52] == 11'h7FF) && (v[51:0] != '0);
        endfunction

        // monotonic unsigned key for non-NaN doubles
        function logic [63:0] dbl_rank(logic [63:0] v);
            return v[63] ? ~v : (v | 64'h8000_0000_0000_0000);
        endfunction

        function logic [3:0] dbl_order(logic [63:0] a, logic [63:0] b);
            if (dbl_is_nan(a) || dbl_is_nan(b))
                return CMP_UN;
            if ((a & DBL_MAG_MASK) == '0 && (b & DBL_MAG_MASK) == '0)
                return CMP_EQ;
            if (dbl_rank(a) < dbl_rank(b))
                return CMP_LT;
            if (dbl_rank(a) > dbl_rank(b))
                return CMP_GT;
            return CMP_EQ;
        endfunction

        function void note_request(req_t rq);
            result_t     res;
            logic [31:0] a_lo;
            logic [31:0] b_lo;
            logic        ctr_ok;
            logic        cond_ok;
            a_lo = rq.operand_a[31:0];
            b_lo = rq.operand_b[31:0];
            res.next_pc = rq.current_pc + PC_STEP;
            res.taken = 1'b0;
            case (rq.req_type)
                REQ_BRANCH:
                begin
                    if (!rq.branch_options[BO2])
                        ctr = ctr - 32'd1;
                    ctr_ok = rq.branch_options[BO2] ||
                             ((ctr != '0) != rq.branch_options[BO3]);
                    cond_ok = rq.branch_options[BO0] ||
                              (cr[31 - rq.cond_bit] == rq.branch_options[BO1]);
                    if (ctr_ok && cond_ok)
                    begin
                        res.taken = 1'b1;
                        res.next_pc = rq.absolute ? rq.target : rq.target + rq.current_pc;
                    end
                    if (rq.link)
                        lr = rq.current_pc + PC_STEP;
                end
                REQ_CMP_S:    put_cr_field(rq.cr_field,
                                           int_order(a_lo, b_lo, 1'b1, rq.summary_overflow));
                REQ_CMP_U:    put_cr_field(rq.cr_field,
                                           int_order(a_lo, b_lo, 1'b0, rq.summary_overflow));
                REQ_CMP_F:    put_cr_field(rq.cr_field, dbl_order(rq.operand_a, rq.operand_b));
                REQ_REC_CR0:  put_cr_field(3'd0, int_order(a_lo, '0, 1'b1, rq.summary_overflow));
                REQ_LOAD_CTR: ctr = a_lo;
                default:      ;
            endcase
            res.cr_value = cr;
            res.ctr_value = ctr;
            res.lr_value = lr;
            pending_results.push_back(res);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing outstanding: next_pc %h", got.next_pc);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("next_pc", want.next_pc, got.next_pc);
            check_field("taken", {31'b0, want.taken}, {31'b0, got.taken});
            check_field("cr_value", want.cr_value, got.cr_value);
            check_field("ctr_value", want.ctr_value, got.ctr_value);
            check_field("lr_value", want.lr_value, got.lr_value);
        endfunction
    endclass

endpackage

>>> tb/tb_top.sv
// Top-level testbench for branch_condition_unit_core: directed then random items.
// Depends on bcu_pkg, bcu_tb_pkg and the RTL of the unit.
module tb_top;
    import bcu_pkg::*;
    import bcu_tb_pkg::*;

    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_ITEMS   = 650;
    localparam int QUIET_TAIL     = 100;   // last items run with no idling

    // double bit patterns
    localparam logic [63:0] DBL_POS_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DBL_NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] DBL_POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] DBL_NEG_INF  = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] DBL_QNAN     = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] DBL_SNAN     = 64'h7FF0_0000_0000_0001;
    localparam logic [63:0] DBL_ONE      = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_NEG_ONE  = 64'hBFF0_0000_0000_0000;
    localparam logic [63:0] DBL_NEG_TWO  = 64'hC000_0000_0000_0000;
    localparam logic [63:0] DBL_MAX_FIN  = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] DBL_MIN_DEN  = 64'h0000_0000_0000_0001;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  req_type;
    logic [4:0]  branch_options;
    logic [4:0]  cond_bit;
    logic [31:0] target;
    logic        absolute;
    logic        link;
    logic [31:0] current_pc;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [2:0]  cr_field;
    logic        summary_overflow;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] next_pc;
    logic        taken;
    logic [31:0] cr_value;
    logic [31:0] ctr_value;
    logic [31:0] lr_value;

    bcu_state_tracker tracker = new();

    // shared knobs between the item sender and the result sink
    bit idling_on = 1'b1;     // random idle bursts on both sides
    int hold_request = 0;     // sink picks this up as a long out_ready hold-off
    int items_sent = 0;

    branch_condition_unit_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .branch_options   (branch_options),
        .cond_bit         (cond_bit),
        .target           (target),
        .absolute         (absolute),
        .link             (link),
        .current_pc       (current_pc),
        .operand_a        (operand_a),
        .operand_b        (operand_b),
        .cr_field         (cr_field),
        .summary_overflow (summary_overflow),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .next_pc          (next_pc),
        .taken            (taken),
        .cr_value         (cr_value),
        .ctr_value        (ctr_value),
        .lr_value         (lr_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case a handshake hangs.
    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Integer operand: upper word is always random (the block must ignore it),
    // low word leans toward the signed/unsigned boundary values.
    function automatic logic [63:0] int_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       v[31:0] = 32'h0000_0000;
            1:       v[31:0] = 32'h7FFF_FFFF;
            2:       v[31:0] = 32'h8000_0000;
            3:       v[31:0] = 32'hFFFF_FFFF;
            4:       v[31:0] = 32'h0000_0001;
            default: ;
        endcase
        return v;
    endfunction

    // Double operand: zeros, infinities, NaNs, denormals, largest finite magnitude and plain random bits.
    function automatic logic [63:0] dbl_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0:       v = DBL_POS_ZERO;
            1:       v = DBL_NEG_ZERO;
            2:       v = DBL_POS_INF;
            3:       v = DBL_NEG_INF;
            4:       v = DBL_QNAN;
            5:       v = DBL_SNAN;
            6:       v[62:52] = 11'h7FF;          // NaN with random payload and sign
            7:       v[62:52] = 11'h000;          // denormal
            8:       v[62:0] = DBL_MAX_FIN[62:0];
            default: ;
        endcase
        return v;
    endfunction

    // Random request of a given kind; every field gets fresh random bits so
    // that unused fields toggle too.
    function automatic req_t random_req(logic [2:0] kind);
        req_t rq;
        rq.req_type = kind;
        rq.branch_options = 5'($urandom);
        rq.cond_bit = 5'($urandom);
        rq.target = $urandom;
        rq.absolute = 1'($urandom);
        rq.link = 1'($urandom);
        rq.current_pc = $urandom;
        rq.cr_field = 3'($urandom);
        rq.summary_overflow = 1'($urandom);
        if (kind == REQ_CMP_F)
        begin
            rq.operand_a = dbl_operand();
            rq.operand_b = dbl_operand();
            // equal operands, or the same magnitude with flipped sign
            case ($urandom_range(0, 5))
                0:       rq.operand_b = rq.operand_a;
                1:       rq.operand_b = rq.operand_a ^ DBL_NEG_ZERO;
                default: ;
            endcase
        end
        else
        begin
            rq.operand_a = int_operand();
            rq.operand_b = int_operand();
            if ($urandom_range(0, 4) == 0)
                rq.operand_b[31:0] = rq.operand_a[31:0];
        end
        return rq;
    endfunction

    // Present one item at the falling edge, hold it until accepted, then
    // maybe leave an idle burst behind it.
    task automatic send_request(input req_t rq);
        @(negedge clk);
        in_valid         <= 1'b1;
        req_type         <= rq.req_type;
        branch_options   <= rq.branch_options;
        cond_bit         <= rq.cond_bit;
        target           <= rq.target;
        absolute         <= rq.absolute;
        link             <= rq.link;
        current_pc       <= rq.current_pc;
        operand_a        <= rq.operand_a;
        operand_b        <= rq.operand_b;
        cr_field         <= rq.cr_field;
        summary_overflow <= rq.summary_overflow;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_request(rq);
        items_sent++;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 16))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
    endtask

    // Stop offering and wait for every outstanding result item.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // Result sink: random stall bursts, plus a long hold-off on request.
    // The hold-off is counted here, independent of the sender.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 16);
            end
        end
    end

    // Sample results at the rising edge; out_ready was set at the falling edge.
    always @(posedge clk)
    begin
        result_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.next_pc = next_pc;
            seen.taken = taken;
            seen.cr_value = cr_value;
            seen.ctr_value = ctr_value;
            seen.lr_value = lr_value;
            tracker.check_result(seen);
        end
    end

    initial
    begin : item_source
        req_t       rq;
        logic [2:0] fld;
        bit         pressure_done;
        bit         drain_done;
        pressure_done = 1'b0;
        drain_done = 1'b0;

        rst_n = 1'b1;
        in_valid = 1'b0;
        req_type = '0;
        branch_options = '0;
        cond_bit = '0;
        target = '0;
        absolute = 1'b0;
        link = 1'b0;
        current_pc = '0;
        operand_a = '0;
        operand_b = '0;
        cr_field = '0;
        summary_overflow = 1'b0;
        // drop reset just after time zero so the asynchronous reset edge is seen
        #1;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---------------- directed items ----------------
        // Branch always, absolute, with link, right out of reset.
        rq = random_req(REQ_BRANCH);
        rq.branch_options = 5'b10100;
        rq.absolute = 1'b1;
        rq.link = 1'b1;
        rq.target = 32'hFFFF_FFFC;
        rq.current_pc = 32'h0000_0000;
        send_request(rq);

        // CTR = 2, then decrement through zero and wrap:
        // bdnz taken (pc+target wraps), bdz taken, bdnz taken at 0xFFFFFFFF, bdz not taken.
        rq = random_req(REQ_LOAD_CTR);
        rq.operand_a = 64'hFFFF_FFFF_0000_0002;
        send_request(rq);
        rq = random_req(REQ_BRANCH);
        rq.branch_options = 5'b10000;
        rq.absolute = 1'b0;
        rq.current_pc = 32'hFFFF_FFF0;
        rq.target = 32'h0000_0020;
        send_request(rq);
        rq = random_req(REQ_BRANCH);
        rq.branch_options = 5'b10010;
        send_request(rq);
        rq = random_req(REQ_BRANCH);
        rq.branch_options = 5'b10000;
        send_request(rq);
        rq = random_req(REQ_BRANCH);
        rq.branch_options = 5'b10010;
        send_request(rq);

        // Integer compares across the sign boundary, equal operands, SO copy.
        rq = random_req(REQ_CMP_S);
        rq.operand_a = 64'h0000_0000_8000_0000;
        rq.operand_b = 64'hFFFF_FFFF_7FFF_FFFF;
        rq.cr_field = 3'd0;
        rq.summary_overflow = 1'b1;
        send_request(rq);
        rq.req_type = REQ_CMP_U;
        rq.cr_field = 3'd7;
        rq.summary_overflow = 1'b0;
        send_request(rq);
        rq = random_req(REQ_CMP_S);
        rq.operand_a = 64'h1234_5678_FFFF_FFFF;
        rq.operand_b = 64'h8765_4321_FFFF_FFFF;
        rq.cr_field = 3'd3;
        rq.summary_overflow = 1'b1;
        send_request(rq);

        // Double compares: signed zeros equal, NaN unordered either side,
        // infinities, negatives, largest finite against smallest denormal.
        rq = random_req(REQ_CMP_F);
        rq.operand_a = DBL_POS_ZERO;
        rq.operand_b = DBL_NEG_ZERO;
        rq.cr_field = 3'd1;
        send_request(rq);
        rq.operand_a = DBL_QNAN;
        rq.operand_b = DBL_ONE;
        rq.cr_field = 3'd2;
        rq.summary_overflow = 1'b1;
        send_request(rq);
        rq.operand_a = DBL_ONE;
        rq.operand_b = DBL_SNAN;
        rq.cr_field = 3'd6;
        send_request(rq);
        rq.operand_a = DBL_NEG_INF;
        rq.operand_b = DBL_POS_INF;
        rq.cr_field = 3'd4;
        send_request(rq);
        rq.operand_a = DBL_NEG_ONE;
        rq.operand_b = DBL_NEG_TWO;
        rq.cr_field = 3'd5;
        send_request(rq);
        rq.operand_a = DBL_MAX_FIN;
        rq.operand_b = DBL_MIN_DEN;
        rq.cr_field = 3'd0;
        send_request(rq);

        // Record CR0: negative with SO, zero, largest positive.
        rq = random_req(REQ_REC_CR0);
        rq.operand_a = 64'h0000_0000_8000_0000;
        rq.summary_overflow = 1'b1;
        send_request(rq);
        rq.operand_a = 64'hFFFF_FFFF_0000_0000;
        rq.summary_overflow = 1'b0;
        send_request(rq);
        rq.operand_a = 64'h0000_0000_7FFF_FFFF;
        send_request(rq);

        // Condition-only branches on CR bit 0 (true) and bit 31 (false),
        // then a branch that ignores both tests.
        rq = random_req(REQ_BRANCH);
        rq.branch_options = 5'b01100;
        rq.cond_bit = 5'd0;
        rq.absolute = 1'b1;
        send_request(rq);
        rq = random_req(REQ_BRANCH);
        rq.branch_options = 5'b00100;
        rq.cond_bit = 5'd31;
        rq.link = 1'b0;
        send_request(rq);
        rq = random_req(REQ_BRANCH);
        rq.branch_options = 5'b11111;
        rq.link = 1'b1;
        send_request(rq);

        // Unused request codes: no state change, pc + 4 wraps.
        rq = random_req(REQ_RESERVED_6);
        rq.current_pc = 32'hFFFF_FFFC;
        send_request(rq);
        rq = random_req(REQ_RESERVED_7);
        send_request(rq);

        rq = random_req(REQ_LOAD_CTR);
        rq.operand_a = 64'h0000_0000_FFFF_FFFF;
        send_request(rq);

        // ---------------- random episodes ----------------
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            if (items_sent >= DIRECTED_ITEMS + RANDOM_ITEMS - QUIET_TAIL)
                idling_on = 1'b0;
            else if ($urandom_range(0, 9) == 0)
                idling_on = ($urandom_range(0, 3) != 0);

            // Long sink hold-off while the sender keeps offering back to back,
            // so the unit fills and drops in_ready.
            if (!pressure_done && items_sent >= 200)
            begin
                idling_on = 1'b0;
                hold_request = 48;
                repeat (12) send_request(random_req(3'($urandom_range(0, 5))));
                idling_on = 1'b1;
                pressure_done = 1'b1;
            end

            // Sender pause until the unit is empty.
            if (!drain_done && items_sent >= 400)
            begin
                wait_drained();
                drain_done = 1'b1;
            end

            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // compare into a field, then branches that test its bits
                    case ($urandom_range(0, 3))
                        0:       rq = random_req(REQ_CMP_S);
                        1:       rq = random_req(REQ_CMP_U);
                        2:       rq = random_req(REQ_CMP_F);
                        default: rq = random_req(REQ_REC_CR0);
                    endcase
                    fld = (rq.req_type == REQ_REC_CR0) ? 3'd0 : rq.cr_field;
                    send_request(rq);
                    repeat ($urandom_range(1, 3))
                    begin
                        rq = random_req(REQ_BRANCH);
                        rq.cond_bit = {fld, 2'($urandom)};
                        if ($urandom_range(0, 3) != 0)
                            rq.branch_options[BO0] = 1'b0;
                        send_request(rq);
                    end
                end
                4, 5, 6:
                begin
                    // counter loop: small CTR, then decrementing branches
                    rq = random_req(REQ_LOAD_CTR);
                    if ($urandom_range(0, 2) != 0)
                        rq.operand_a[31:0] = $urandom_range(0, 4);
                    send_request(rq);
                    repeat ($urandom_range(1, 6))
                    begin
                        rq = random_req(REQ_BRANCH);
                        rq.branch_options[BO2] = 1'b0;
                        send_request(rq);
                    end
                end
                7, 8:    send_request(random_req(3'($urandom_range(0, 5))));
                default: send_request(random_req(3'($urandom_range(0, 7))));
            endcase
        end

        // Drain, then keep watching the output to catch stray result items.
        wait_drained();
        repeat (8) @(posedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> branch_condition_unit_core.f
+incdir+rtl/core
rtl/core/bcu_pkg.sv
rtl/core/bcu_cmp.sv
rtl/core/bcu_branch.sv
rtl/core/branch_condition_unit_core.sv
rtl/core/bcu_checker.sv
tb/bcu_tb_pkg.sv
tb/tb_top.sv
